// ===== hw/rtl/usi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package usi_pkg;

    typedef enum logic [2:0] {
        FN_TICK  = 3'd0,
        FN_READ  = 3'd1,
        FN_WRITE = 3'd2,
        FN_TIMER = 3'd3,
        FN_ACK   = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        REG_CTRL = 2'd0,
        REG_STAT = 2'd1,
        REG_DATA = 2'd2,
        REG_BUF  = 2'd3
    } t_reg;

    localparam logic [1:0] CS_EXT   = 2'd0;
    localparam logic [1:0] CS_EXTSW = 2'd1;
    localparam logic [1:0] CS_TMR   = 2'd2;
    localparam logic [1:0] CS_SW    = 2'd3;

    // control bit positions
    localparam int CB_SIE = 5;
    localparam int CB_OIE = 4;

    // status flag positions
    localparam int SF_START = 3;
    localparam int SF_OVF   = 2;
    localparam int SF_STOP  = 1;
    localparam int SF_COLL  = 0;

    typedef struct packed {
        logic [5:0] ctrl;
        logic [3:0] flags;
        logic [3:0] count;
        logic [7:0] data;
        logic       last_sda;
        logic       last_scl;
    } t_state;

    typedef struct packed {
        logic [7:0] read_data;
        logic       data_out;
        logic       data_out_drive;
        logic       scl_toggle;
        logic       irq_request;
        logic       irq_source;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/usi_exec.sv =====
`timescale 1ns / 1ps
`default_nettype none

module usi_exec import usi_pkg::*; #(
    parameter int PENDING_MAX = 8,
    parameter int PW          = 4
) (
    input  t_state          i_state,
    input  logic [PW-1:0]   i_wait,
    input  logic [2:0]      i_func,
    input  logic [1:0]      i_reg_sel,
    input  logic [7:0]      i_write_data,
    input  logic            i_sda_level,
    input  logic            i_scl_level,
    output t_state          o_state,
    output logic [PW-1:0]   o_wait,
    output t_result         o_res
);

    t_state      s;
    t_state      t;
    logic [1:0]  cs;
    logic [1:0]  ncs;
    logic [3:0]  n_shift;
    logic        toggle;
    logic [7:0]  rd;
    logic [15:0] ext;
    logic [7:0]  mask;
    logic [4:0]  cnt5;
    logic        tw_new;
    logic        start_act;
    logic        ovf_act;

    always_comb begin
        s       = i_state;
        cs      = s.ctrl[1:0];
        ncs     = i_write_data[3:2];
        n_shift = 4'd0;
        toggle  = 1'b0;
        rd      = 8'h00;
        o_wait  = i_wait;
        case (t_func'(i_func))
            FN_TICK: begin
                if ((|s.ctrl[3:2]) && s.last_scl && i_scl_level) begin
                    if (s.last_sda && !i_sda_level) begin
                        s.flags[SF_START] = 1'b1;
                        s.flags[SF_STOP]  = 1'b0;
                        s.flags[SF_COLL]  = 1'b0;
                    end
                    if (!s.last_sda && i_sda_level) begin
                        s.flags[SF_STOP] = 1'b1;
                    end
                end
                if ((cs == CS_EXT || cs == CS_EXTSW) && !s.last_scl && i_scl_level) begin
                    n_shift = 4'd1;
                end else if (cs == CS_TMR && i_wait != '0) begin
                    n_shift = 4'(i_wait);
                    o_wait  = '0;
                end
                s.last_sda = i_sda_level;
                s.last_scl = i_scl_level;
            end
            FN_READ: begin
                unique case (t_reg'(i_reg_sel))
                    REG_CTRL: rd = {s.ctrl, 2'b00};
                    REG_STAT: rd = {s.flags, s.count};
                    REG_DATA: rd = s.data;
                    REG_BUF:  rd = 8'h00;
                    default:  rd = 8'h00;
                endcase
            end
            FN_WRITE: begin
                unique case (t_reg'(i_reg_sel))
                    REG_CTRL: begin
                        s.ctrl = i_write_data[7:2];
                        if (i_write_data[1] && (ncs == CS_EXTSW || ncs == CS_SW)) begin
                            n_shift = n_shift + 4'd1;
                        end
                        if (i_write_data[0]) begin
                            toggle = 1'b1;
                            if (ncs == CS_EXT || ncs == CS_EXTSW) begin
                                n_shift = n_shift + 4'd1;
                            end
                        end
                    end
                    REG_STAT: begin
                        s.flags = s.flags & ~i_write_data[7:4];
                        s.count = i_write_data[3:0];
                        if (i_write_data[3:0] != 4'd0) begin
                            s.flags[SF_START] = 1'b0;
                        end
                    end
                    REG_DATA: s.data = i_write_data;
                    REG_BUF:  ;
                    default:  ;
                endcase
            end
            FN_TIMER: begin
                if (cs == CS_TMR && 32'(i_wait) < PENDING_MAX) begin
                    o_wait = i_wait + PW'(1);
                end
            end
            FN_ACK: begin
                if (s.ctrl[CB_SIE] && s.flags[SF_START]) begin
                    s.flags[SF_START] = 1'b0;
                end else if (s.ctrl[CB_OIE] && s.flags[SF_OVF]) begin
                    s.flags[SF_OVF] = 1'b0;
                end
            end
            default: ;
        endcase

        // closed-form shift by n_shift bits, all taking in sda
        t      = s;
        tw_new = |s.ctrl[3:2];
        ext    = {s.data, {8{i_sda_level}}} << n_shift;
        mask   = ~(8'hFF >> n_shift);
        cnt5   = {1'b0, s.count} + {1'b0, n_shift};
        if (n_shift != 4'd0) begin
            if (tw_new && !i_sda_level && ((s.data & mask) != 8'h00)) begin
                t.flags[SF_COLL] = 1'b1;
            end
            if (cnt5[4]) begin
                t.flags[SF_OVF] = 1'b1;
            end
            t.data  = ext[15:8];
            t.count = cnt5[3:0];
        end

        start_act = t.ctrl[CB_SIE] && t.flags[SF_START];
        ovf_act   = t.ctrl[CB_OIE] && t.flags[SF_OVF];

        o_state                = t;
        o_res.read_data        = rd;
        o_res.data_out         = t.data[7];
        o_res.data_out_drive   = ~(|t.ctrl[3:2]);
        o_res.scl_toggle       = toggle;
        o_res.irq_request      = start_act || ovf_act;
        o_res.irq_source       = !start_act && ovf_act;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/usi_serial_shift_interface_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// USI shift block. Every accepted word (tick, register read or write, timer0 event or
// interrupt acknowledge) gives exactly one result word. A word is held in the input
// register, is executed against the shift/counter/flag state in one combinational
// pass and lands in the result register, which is loaded only while the output is not
// stalled; one word per cycle is sustained while the output is not stalled.
// Timer0 shifts queue up to PENDING_MAX and are applied together on the next tick.
module usi_serial_shift_interface_unit import usi_pkg::*; #(
    parameter int PENDING_MAX = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_func,
    input  logic [1:0] i_reg_sel,
    input  logic [7:0] i_write_data,
    input  logic       i_sda_level,
    input  logic       i_scl_level,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data,
    output logic       o_data_out,
    output logic       o_data_out_drive,
    output logic       o_scl_toggle,
    output logic       o_irq_request,
    output logic       o_irq_source
);

    localparam int PW = $clog2(PENDING_MAX + 1);

    logic          r_in_valid;
    logic [2:0]    r_func;
    logic [1:0]    r_reg_sel;
    logic [7:0]    r_write_data;
    logic          r_sda_level;
    logic          r_scl_level;
    t_state        r_state;
    logic [PW-1:0] r_wait;
    logic          r_out_valid;
    t_result       r_res;

    t_state        n_state;
    logic [PW-1:0] n_wait;
    t_result       n_res;
    logic          w_adv;

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_adv;

    usi_exec #(
        .PENDING_MAX (PENDING_MAX),
        .PW          (PW)
    ) u_exec (
        .i_state      (r_state),
        .i_wait       (r_wait),
        .i_func       (r_func),
        .i_reg_sel    (r_reg_sel),
        .i_write_data (r_write_data),
        .i_sda_level  (r_sda_level),
        .i_scl_level  (r_scl_level),
        .o_state      (n_state),
        .o_wait       (n_wait),
        .o_res        (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_func       <= i_func;
            r_reg_sel    <= i_reg_sel;
            r_write_data <= i_write_data;
            r_sda_level  <= i_sda_level;
            r_scl_level  <= i_scl_level;
        end
        if (w_adv && r_in_valid) begin
            r_res <= n_res;
        end
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_wait      <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                    r_wait  <= n_wait;
                end
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_res.read_data;
    assign o_data_out       = r_res.data_out;
    assign o_data_out_drive = r_res.data_out_drive;
    assign o_scl_toggle     = r_res.scl_toggle;
    assign o_irq_request    = r_res.irq_request;
    assign o_irq_source     = r_res.irq_source;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import usi_pkg::*;

    localparam int BACKLOG_LIMIT = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int CALM_TAIL     = 100;

    typedef struct {
        logic [2:0] fn;
        logic [1:0] sel;
        logic [7:0] wd;
        logic       sda;
        logic       scl;
    } t_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [2:0] i_func;
    logic [1:0] i_reg_sel;
    logic [7:0] i_write_data;
    logic       i_sda_level;
    logic       i_scl_level;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_read_data;
    logic       o_data_out;
    logic       o_data_out_drive;
    logic       o_scl_toggle;
    logic       o_irq_request;
    logic       o_irq_source;

    t_word   words_to_send[$];
    t_result usi_results_due[$];

    logic [5:0]  usi_ctrl;
    logic [3:0]  usi_flags;
    logic [3:0]  usi_count;
    logic [7:0]  usi_data;
    logic        usi_last_sda;
    logic        usi_last_scl;
    int unsigned usi_timer_backlog;

    int errors;
    int cycles;
    int send_gap;
    int sink_hold;

    usi_serial_shift_interface_unit #(.PENDING_MAX(BACKLOG_LIMIT)) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_reg_sel        (i_reg_sel),
        .i_write_data     (i_write_data),
        .i_sda_level      (i_sda_level),
        .i_scl_level      (i_scl_level),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_read_data      (o_read_data),
        .o_data_out       (o_data_out),
        .o_data_out_drive (o_data_out_drive),
        .o_scl_toggle     (o_scl_toggle),
        .o_irq_request    (o_irq_request),
        .o_irq_source     (o_irq_source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
    end

    function automatic logic two_wire();
        return usi_ctrl[3:2] != 2'b00;
    endfunction

    // n shifts in one go, all taking in the same bit
    function automatic void shift_bits(int unsigned n, logic b);
        logic [7:0] mask;
        logic [4:0] sum;
        if (n == 0) return;
        if (n > 8) n = 8;
        mask = 8'hFF << (8 - n);
        if (two_wire() && !b && (usi_data & mask) != 8'h00) usi_flags[SF_COLL] = 1'b1;
        if (n == 8) usi_data = {8{b}};
        else usi_data = (usi_data << n) | (b ? ((1 << n) - 1) : 0);
        sum = usi_count + n;
        if (sum >= 16) usi_flags[SF_OVF] = 1'b1;
        usi_count = sum[3:0];
    endfunction

    function automatic t_result run_usi_word(logic [2:0] fn, logic [1:0] sel, logic [7:0] wd,
                                             logic sda, logic scl);
        t_result    r;
        logic [1:0] cs;
        logic [1:0] ncs;
        logic       st;
        logic       ov;
        r  = '0;
        cs = usi_ctrl[1:0];
        case (fn)
            FN_TICK: begin
                if (two_wire() && usi_last_scl && scl) begin
                    if (usi_last_sda && !sda) begin
                        usi_flags[SF_START] = 1'b1;
                        usi_flags[SF_STOP]  = 1'b0;
                        usi_flags[SF_COLL]  = 1'b0;
                    end
                    if (!usi_last_sda && sda) usi_flags[SF_STOP] = 1'b1;
                end
                if ((cs == CS_EXT || cs == CS_EXTSW) && !usi_last_scl && scl) shift_bits(1, sda);
                if (cs == CS_TMR && usi_timer_backlog > 0) begin
                    shift_bits(usi_timer_backlog, sda);
                    usi_timer_backlog = 0;
                end
                usi_last_sda = sda;
                usi_last_scl = scl;
            end
            FN_READ: begin
                case (sel)
                    REG_CTRL: r.read_data = {usi_ctrl, 2'b00};
                    REG_STAT: r.read_data = {usi_flags, usi_count};
                    REG_DATA: r.read_data = usi_data;
                    default:  r.read_data = 8'h00;
                endcase
            end
            FN_WRITE: begin
                case (sel)
                    REG_CTRL: begin
                        ncs      = wd[3:2];
                        usi_ctrl = wd[7:2];
                        if (wd[1] && (ncs == CS_EXTSW || ncs == CS_SW)) shift_bits(1, sda);
                        if (wd[0]) begin
                            r.scl_toggle = 1'b1;
                            if (ncs == CS_EXT || ncs == CS_EXTSW) shift_bits(1, sda);
                        end
                    end
                    REG_STAT: begin
                        usi_flags = usi_flags & ~wd[7:4];
                        usi_count = wd[3:0];
                        if (wd[3:0] != 4'h0) usi_flags[SF_START] = 1'b0;
                    end
                    REG_DATA: usi_data = wd;
                    default: ;
                endcase
            end
            FN_TIMER: begin
                if (cs == CS_TMR && usi_timer_backlog < BACKLOG_LIMIT)
                    usi_timer_backlog = usi_timer_backlog + 1;
            end
            FN_ACK: begin
                if (usi_ctrl[CB_SIE] && usi_flags[SF_START]) usi_flags[SF_START] = 1'b0;
                else if (usi_ctrl[CB_OIE] && usi_flags[SF_OVF]) usi_flags[SF_OVF] = 1'b0;
            end
            default: ;
        endcase
        st = usi_ctrl[CB_SIE] && usi_flags[SF_START];
        ov = usi_ctrl[CB_OIE] && usi_flags[SF_OVF];
        r.data_out       = usi_data[7];
        r.data_out_drive = !two_wire();
        r.irq_request    = st || ov;
        r.irq_source     = !st && ov;
        return r;
    endfunction

    function automatic void queue_word(logic [2:0] fn, logic [1:0] sel, logic [7:0] wd,
                                       logic sda, logic scl);
        t_word w;
        w.fn  = fn;
        w.sel = sel;
        w.wd  = wd;
        w.sda = sda;
        w.scl = scl;
        words_to_send.push_back(w);
    endfunction

    function automatic void pin_tick(logic sda, logic scl);
        queue_word(FN_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), sda, scl);
    endfunction

    function automatic void reg_write(logic [1:0] sel, logic [7:0] wd);
        queue_word(FN_WRITE, sel, wd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic void reg_read(logic [1:0] sel);
        queue_word(FN_READ, sel, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    endfunction

    function automatic void random_word();
        queue_word(3'($urandom_range(0, 4)), 2'($urandom_range(0, 3)),
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    endfunction

    task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, what, want, got);
            errors++;
        end
    endtask

    // driver: prediction happens at the edge where the word is taken
    always @(posedge i_clk) begin : drive
        logic  take;
        t_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            take = i_in_valid && !o_in_stall;
            if (take)
                usi_results_due.push_back(run_usi_word(i_func, i_reg_sel, i_write_data,
                                                       i_sda_level, i_scl_level));
            if (!i_in_valid || take) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (words_to_send.size() >= CALM_TAIL && (cycles % 160) >= 50 &&
                             $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 2);
                    i_in_valid <= 1'b0;
                end else if (words_to_send.size() != 0) begin
                    w = words_to_send.pop_front();
                    i_in_valid   <= 1'b1;
                    i_func       <= w.fn;
                    i_reg_sel    <= w.sel;
                    i_write_data <= w.wd;
                    i_sda_level  <= w.sda;
                    i_scl_level  <= w.scl;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            sink_hold = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got.read_data      = o_read_data;
                got.data_out       = o_data_out;
                got.data_out_drive = o_data_out_drive;
                got.scl_toggle     = o_scl_toggle;
                got.irq_request    = o_irq_request;
                got.irq_source     = o_irq_source;
                if (usi_results_due.size() == 0) begin
                    $display("%0t: word with none pending, expected nothing got %h",
                             $time, got);
                    errors++;
                end else begin
                    want = usi_results_due.pop_front();
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("data_out", want.data_out, got.data_out);
                    check_field("data_out_drive", want.data_out_drive, got.data_out_drive);
                    check_field("scl_toggle", want.scl_toggle, got.scl_toggle);
                    check_field("irq_request", want.irq_request, got.irq_request);
                    check_field("irq_source", want.irq_source, got.irq_source);
                end
            end
            if (sink_hold > 0) begin
                sink_hold--;
                i_out_stall <= 1'b1;
            end else if (words_to_send.size() >= CALM_TAIL && (cycles % 224) >= 70 &&
                         $urandom_range(0, 5) == 0) begin
                sink_hold = $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : timeout
        while (cycles < CYCLE_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int         kind;
        int         n;
        logic [1:0] ie;
        logic [1:0] wm;
        logic [1:0] cs;
        logic       b;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_func       = FN_TICK;
        i_reg_sel    = REG_CTRL;
        i_write_data = 8'h00;
        i_sda_level  = 1'b0;
        i_scl_level  = 1'b0;
        i_out_stall  = 1'b0;
        errors       = 0;
        cycles       = 0;
        send_gap     = 0;
        sink_hold    = 0;
        usi_ctrl          = '0;
        usi_flags         = '0;
        usi_count         = '0;
        usi_data          = '0;
        usi_last_sda      = 1'b0;
        usi_last_scl      = 1'b0;
        usi_timer_backlog = 0;

        // directed: reset values, two-wire start/stop, collision, overflow, timer saturation
        queue_word(FN_READ, REG_CTRL, 8'h00, 1'b0, 1'b0);
        queue_word(FN_READ, REG_STAT, 8'hFF, 1'b1, 1'b1);
        queue_word(FN_WRITE, REG_DATA, 8'hFF, 1'b1, 1'b0);
        queue_word(FN_WRITE, REG_CTRL, 8'hBF, 1'b0, 1'b0);
        queue_word(FN_TICK, REG_CTRL, 8'h00, 1'b1, 1'b1);
        queue_word(FN_TICK, REG_CTRL, 8'h00, 1'b0, 1'b1);
        queue_word(FN_ACK, REG_CTRL, 8'h00, 1'b0, 1'b0);
        queue_word(FN_TICK, REG_CTRL, 8'h00, 1'b1, 1'b1);
        queue_word(FN_READ, REG_STAT, 8'h00, 1'b0, 1'b0);
        queue_word(FN_WRITE, REG_STAT, 8'hFF, 1'b0, 1'b0);
        queue_word(FN_WRITE, REG_CTRL, 8'h53, 1'b1, 1'b0);
        queue_word(FN_READ, REG_STAT, 8'h00, 1'b0, 1'b0);
        queue_word(FN_ACK, REG_CTRL, 8'h00, 1'b0, 1'b0);
        queue_word(FN_WRITE, REG_CTRL, 8'h08, 1'b0, 1'b0);
        repeat (BACKLOG_LIMIT + 1) queue_word(FN_TIMER, REG_CTRL, 8'h00, 1'b0, 1'b0);
        queue_word(FN_TICK, REG_CTRL, 8'h00, 1'b1, 1'b0);
        queue_word(FN_READ, REG_DATA, 8'h00, 1'b0, 1'b0);
        queue_word(FN_WRITE, REG_BUF, 8'hAA, 1'b1, 1'b1);
        queue_word(FN_READ, REG_BUF, 8'h00, 1'b0, 1'b0);
        queue_word(FN_WRITE, REG_STAT, 8'h00, 1'b0, 1'b0);

        while (words_to_send.size() < 730) begin
            kind = $urandom_range(0, 9);
            ie   = 2'($urandom_range(0, 3));
            case (kind)
                0, 1, 2: begin
                    // two-wire frame: start, clocked bits, optional stop
                    wm = 2'($urandom_range(1, 3));
                    reg_write(REG_CTRL, {ie, wm, 1'b0, 1'($urandom_range(0, 1)), 2'b00});
                    if ($urandom_range(0, 1)) reg_write(REG_DATA, 8'($urandom_range(0, 255)));
                    reg_write(REG_STAT, {4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))});
                    pin_tick(1'b1, 1'b1);
                    pin_tick(1'b0, 1'b1);
                    n = $urandom_range(1, 18);
                    repeat (n) begin
                        b = 1'($urandom_range(0, 1));
                        pin_tick(b, 1'b0);
                        pin_tick(b, 1'b1);
                        if ($urandom_range(0, 5) == 0) reg_read(2'($urandom_range(0, 3)));
                        if ($urandom_range(0, 7) == 0)
                            queue_word(FN_ACK, REG_CTRL, 8'h00, b, 1'b1);
                        pin_tick(b, 1'b0);
                    end
                    if ($urandom_range(0, 3) != 0) begin
                        pin_tick(1'b0, 1'b0);
                        pin_tick(1'b0, 1'b1);
                        pin_tick(1'b1, 1'b1);
                    end
                    reg_read(REG_STAT);
                end
                3, 4: begin
                    // three-wire style, external clock with software strobes
                    cs = 2'($urandom_range(0, 1));
                    reg_write(REG_CTRL, {ie, 2'b00, cs, 2'b00});
                    n = $urandom_range(2, 20);
                    repeat (n) begin
                        if ($urandom_range(0, 4) == 0)
                            reg_write(REG_CTRL, {ie, 2'b00, cs, 2'($urandom_range(0, 3))});
                        else
                            pin_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    end
                    reg_read(REG_DATA);
                    reg_read(REG_STAT);
                end
                5: begin
                    wm = 2'($urandom_range(0, 3));
                    cs = $urandom_range(0, 1) ? CS_SW : CS_EXTSW;
                    n = $urandom_range(2, 12);
                    repeat (n) reg_write(REG_CTRL, {ie, wm, cs, 2'($urandom_range(0, 3))});
                    reg_read(REG_DATA);
                    reg_read(REG_CTRL);
                end
                6: begin
                    // timer0 events queued then released by a tick
                    reg_write(REG_CTRL, {ie, 2'($urandom_range(0, 3)), CS_TMR, 2'b00});
                    n = $urandom_range(0, 11);
                    repeat (n) begin
                        queue_word(FN_TIMER, 2'($urandom_range(0, 3)),
                                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)));
                        if ($urandom_range(0, 5) == 0) reg_read(2'($urandom_range(0, 3)));
                    end
                    if ($urandom_range(0, 4) == 0)
                        reg_write(REG_CTRL, {ie, 2'($urandom_range(0, 3)),
                                             2'($urandom_range(0, 3)), 2'b00});
                    pin_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    reg_read(REG_DATA);
                    reg_read(REG_STAT);
                end
                7: begin
                    reg_write(REG_STAT, 8'($urandom_range(0, 255)));
                    queue_word(FN_ACK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    reg_read(REG_STAT);
                    queue_word(FN_ACK, REG_CTRL, 8'h00, 1'b0, 1'b0);
                end
                default: begin
                    repeat (4) random_word();
                end
            endcase
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_to_send.size() != 0 || i_in_valid) @(posedge i_clk);
        while (usi_results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/usi_pkg.sv
hw/rtl/usi_exec.sv
hw/rtl/usi_serial_shift_interface_unit.sv
dv/testbench.sv
